// ----- hdl/tfn_pkg.sv -----
package tfn_pkg;

	localparam int unsigned AXES      = 3;
	localparam int unsigned COORD_W   = 16;
	localparam int unsigned EDGE_W    = 17;
	localparam int unsigned PROD_W    = 34;
	localparam int unsigned CROSS_W   = 35;
	localparam int unsigned MAG_W     = 34;
	localparam int unsigned NMAG_W    = 30;
	localparam int unsigned NORM_BIT  = 29;
	localparam int unsigned SQ_W      = 60;
	localparam int unsigned SUM_W     = 62;
	localparam int unsigned ROOT_W    = 31;
	localparam int unsigned DEN_W     = 32;
	localparam int unsigned NUM_W     = 46;
	localparam int unsigned QUO_W     = 15;
	localparam int unsigned FRAC_SH   = 15;
	localparam int unsigned ONE_Q14   = 16384;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_a_x;
		logic signed [COORD_W-1:0] vertex_a_y;
		logic signed [COORD_W-1:0] vertex_a_z;
		logic signed [COORD_W-1:0] vertex_b_x;
		logic signed [COORD_W-1:0] vertex_b_y;
		logic signed [COORD_W-1:0] vertex_b_z;
		logic signed [COORD_W-1:0] vertex_c_x;
		logic signed [COORD_W-1:0] vertex_c_y;
		logic signed [COORD_W-1:0] vertex_c_z;
	} vert_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] normal_x;
		logic signed [COORD_W-1:0] normal_y;
		logic signed [COORD_W-1:0] normal_z;
		logic                      degenerate;
	} norm_t;

	// Normalized magnitudes and signs that ride along with the root extraction.
	typedef struct packed {
		logic [AXES-1:0][NMAG_W-1:0] mag;
		logic [AXES-1:0]             neg;
		logic                        degen;
	} side_t;

	typedef struct packed {
		logic [SUM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		side_t             side;
	} sqrt_st_t;

	typedef struct packed {
		logic [DEN_W-1:0]            den;
		logic [AXES-1:0][NUM_W-1:0]  rem;
		logic [AXES-1:0][QUO_W-1:0]  quo;
		logic [AXES-1:0]             neg;
		logic                        degen;
	} div_st_t;

endpackage

// ----- hdl/tfn_front.sv -----
module tfn_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid,
	input  tfn_pkg::vert_t           data,
	output logic                     sum_valid,
	output logic [tfn_pkg::SUM_W-1:0] sum,
	output tfn_pkg::side_t           side
);

	logic signed [tfn_pkg::EDGE_W-1:0]  e0_s1 [tfn_pkg::AXES];
	logic signed [tfn_pkg::EDGE_W-1:0]  e1_s1 [tfn_pkg::AXES];
	logic signed [tfn_pkg::PROD_W-1:0]  p_s2 [6];
	logic [tfn_pkg::AXES-1:0][tfn_pkg::MAG_W-1:0] mag_s3;
	logic [tfn_pkg::AXES-1:0]           neg_s3;
	tfn_pkg::side_t                     side_s4;
	logic [tfn_pkg::AXES-1:0][tfn_pkg::SQ_W-1:0] sq_s5;
	tfn_pkg::side_t                     side_s5;
	logic [tfn_pkg::SUM_W-1:0]          sum_s6;
	tfn_pkg::side_t                     side_s6;
	logic [5:0]                         valid_q;

	logic signed [tfn_pkg::CROSS_W-1:0] cr [tfn_pkg::AXES];
	logic [tfn_pkg::MAG_W-1:0]          m_or;
	logic [5:0]                         lead;
	logic [5:0]                         rsh;
	logic [5:0]                         lsh;
	logic [tfn_pkg::AXES-1:0][tfn_pkg::NMAG_W-1:0] nmag;

	always_comb begin
		for (int k = 0; k < tfn_pkg::AXES; k++) begin
			cr[k] = tfn_pkg::CROSS_W'(p_s2[2*k]) - tfn_pkg::CROSS_W'(p_s2[2*k+1]);
		end
	end

	// The leading one of the OR of the magnitudes is the leading one of the largest.
	always_comb begin
		m_or = mag_s3[0] | mag_s3[1] | mag_s3[2];
		lead = '0;
		for (int b = 0; b < tfn_pkg::MAG_W; b++) begin
			if (m_or[b]) lead = 6'(b);
		end
		rsh = lead - 6'(tfn_pkg::NORM_BIT);
		lsh = 6'(tfn_pkg::NORM_BIT) - lead;
		for (int k = 0; k < tfn_pkg::AXES; k++) begin
			if (lead >= 6'(tfn_pkg::NORM_BIT)) begin
				nmag[k] = tfn_pkg::NMAG_W'(mag_s3[k] >> rsh);
			end else begin
				nmag[k] = tfn_pkg::NMAG_W'(mag_s3[k] << lsh);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[4:0], valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1[0] <= tfn_pkg::EDGE_W'(data.vertex_b_x) - tfn_pkg::EDGE_W'(data.vertex_a_x);
			e0_s1[1] <= tfn_pkg::EDGE_W'(data.vertex_b_y) - tfn_pkg::EDGE_W'(data.vertex_a_y);
			e0_s1[2] <= tfn_pkg::EDGE_W'(data.vertex_b_z) - tfn_pkg::EDGE_W'(data.vertex_a_z);
			e1_s1[0] <= tfn_pkg::EDGE_W'(data.vertex_c_x) - tfn_pkg::EDGE_W'(data.vertex_b_x);
			e1_s1[1] <= tfn_pkg::EDGE_W'(data.vertex_c_y) - tfn_pkg::EDGE_W'(data.vertex_b_y);
			e1_s1[2] <= tfn_pkg::EDGE_W'(data.vertex_c_z) - tfn_pkg::EDGE_W'(data.vertex_b_z);

			p_s2[0] <= e0_s1[1] * e1_s1[2];
			p_s2[1] <= e0_s1[2] * e1_s1[1];
			p_s2[2] <= e0_s1[2] * e1_s1[0];
			p_s2[3] <= e0_s1[0] * e1_s1[2];
			p_s2[4] <= e0_s1[0] * e1_s1[1];
			p_s2[5] <= e0_s1[1] * e1_s1[0];

			for (int k = 0; k < tfn_pkg::AXES; k++) begin
				neg_s3[k] <= cr[k][tfn_pkg::CROSS_W-1];
				mag_s3[k] <= cr[k][tfn_pkg::CROSS_W-1] ?
					tfn_pkg::MAG_W'(-cr[k]) : tfn_pkg::MAG_W'(cr[k]);
			end

			side_s4.mag   <= nmag;
			side_s4.neg   <= neg_s3;
			side_s4.degen <= (m_or == '0);

			for (int k = 0; k < tfn_pkg::AXES; k++) begin
				sq_s5[k] <= tfn_pkg::SQ_W'(side_s4.mag[k]) * tfn_pkg::SQ_W'(side_s4.mag[k]);
			end
			side_s5 <= side_s4;

			sum_s6  <= tfn_pkg::SUM_W'(sq_s5[0]) + tfn_pkg::SUM_W'(sq_s5[1])
				+ tfn_pkg::SUM_W'(sq_s5[2]);
			side_s6 <= side_s5;
		end
	end

	assign sum_valid = valid_q[5];
	assign sum       = sum_s6;
	assign side      = side_s6;

endmodule

// ----- hdl/tfn_sqrt_cell.sv -----
module tfn_sqrt_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  tfn_pkg::sqrt_st_t   st_in,
	output logic                valid_out,
	output tfn_pkg::sqrt_st_t   st_out
);

	logic [63:0]        trial;
	tfn_pkg::sqrt_st_t  nxt;
	logic               valid_q;
	tfn_pkg::sqrt_st_t  st_q;

	// Accepting root bit BIT grows the square by 2^(BIT+1)*root + 2^(2*BIT).
	always_comb begin
		trial = (64'(st_in.root) << (BIT + 1)) + (64'(1) << (2 * BIT));
		nxt   = st_in;
		if (64'(st_in.rem) >= trial) begin
			nxt.rem  = st_in.rem - tfn_pkg::SUM_W'(trial);
			nxt.root = st_in.root | (tfn_pkg::ROOT_W'(1) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign st_out    = st_q;

endmodule

// ----- hdl/tfn_div_cell.sv -----
module tfn_div_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  tfn_pkg::div_st_t   st_in,
	output logic               valid_out,
	output tfn_pkg::div_st_t   st_out
);

	logic [63:0]       dsh;
	tfn_pkg::div_st_t  nxt;
	logic              valid_q;
	tfn_pkg::div_st_t  st_q;

	// One restoring quotient bit for each of the three lanes.
	always_comb begin
		dsh = 64'(st_in.den) << BIT;
		nxt = st_in;
		for (int k = 0; k < tfn_pkg::AXES; k++) begin
			if (64'(st_in.rem[k]) >= dsh) begin
				nxt.rem[k] = st_in.rem[k] - tfn_pkg::NUM_W'(dsh);
				nxt.quo[k] = st_in.quo[k] | (tfn_pkg::QUO_W'(1) << BIT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign st_out    = st_q;

endmodule

// ----- hdl/triangle_face_normal_core.sv -----
// Channel   Direction  Handshake                Payload
// vert      in         vert_valid / vert_ready  vert_data (tfn_pkg::vert_t)
// norm      out        norm_valid / norm_ready  norm_data (tfn_pkg::norm_t)
//
// One transaction is accepted every clock cycle unless norm stalls with the output register full.
// The pipeline runs through the front stages, the 31 root cells, the divider prep register,
// the 15 divider cells and the output register. Reset clears only the valid bits of the
// pipeline and the output register. A stall on norm freezes the whole pipeline, so
// vert_ready follows norm_ready whenever the output register is full.
module triangle_face_normal_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vert_valid,
	output logic            vert_ready,
	input  tfn_pkg::vert_t  vert_data,
	output logic            norm_valid,
	input  logic            norm_ready,
	output tfn_pkg::norm_t  norm_data
);

	localparam int unsigned NSQ  = tfn_pkg::ROOT_W;
	localparam int unsigned NDIV = tfn_pkg::QUO_W;

	logic                       en;
	logic                       front_valid;
	logic [tfn_pkg::SUM_W-1:0]  front_sum;
	tfn_pkg::side_t             front_side;

	logic                       sq_valid [NSQ+1];
	tfn_pkg::sqrt_st_t          sq_st    [NSQ+1];

	logic                       div_valid [NDIV+1];
	tfn_pkg::div_st_t           div_st    [NDIV+1];
	logic                       prep_valid_q;
	tfn_pkg::div_st_t           prep_st_q;

	logic                       norm_valid_q;
	tfn_pkg::norm_t             norm_data_q;
	tfn_pkg::norm_t             result;
	logic [tfn_pkg::QUO_W-1:0]  qc;

	// The whole pipeline moves together whenever the output register can take a result.
	assign en         = !norm_valid_q || norm_ready;
	assign vert_ready = en;

	// Edges, cross product, normalization to [2^29, 2^30) and the sum of squares.
	tfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (vert_valid),
		.data      (vert_data),
		.sum_valid (front_valid),
		.sum       (front_sum),
		.side      (front_side)
	);

	assign sq_valid[0]      = front_valid;
	assign sq_st[0].rem     = front_sum;
	assign sq_st[0].root    = '0;
	assign sq_st[0].side    = front_side;

	// Integer square root, one root bit per cell, most significant bit first.
	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		tfn_sqrt_cell #(
			.BIT (NSQ - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (sq_valid[i]),
			.st_in     (sq_st[i]),
			.valid_out (sq_valid[i+1]),
			.st_out    (sq_st[i+1])
		);
	end

	// Rounded quotient: floor((|c| * 2^15 + r) / (2r)).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_valid_q <= 1'b0;
		end else if (en) begin
			prep_valid_q <= sq_valid[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_st_q.den   <= {sq_st[NSQ].root, 1'b0};
			prep_st_q.neg   <= sq_st[NSQ].side.neg;
			prep_st_q.degen <= sq_st[NSQ].side.degen;
			for (int k = 0; k < tfn_pkg::AXES; k++) begin
				prep_st_q.rem[k] <= (tfn_pkg::NUM_W'(sq_st[NSQ].side.mag[k]) << tfn_pkg::FRAC_SH)
					+ tfn_pkg::NUM_W'(sq_st[NSQ].root);
				prep_st_q.quo[k] <= '0;
			end
		end
	end

	assign div_valid[0] = prep_valid_q;
	assign div_st[0]    = prep_st_q;

	// Restoring division for the three components side by side, one quotient bit per cell.
	for (genvar i = 0; i < NDIV; i++) begin : g_div
		tfn_div_cell #(
			.BIT (NDIV - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (div_valid[i]),
			.st_in     (div_st[i]),
			.valid_out (div_valid[i+1]),
			.st_out    (div_st[i+1])
		);
	end

	// Clamp each magnitude to ONE_Q14 and apply signs; a degenerate triangle gives a zero vector with the flag set.
	always_comb begin
		result = '0;
		result.degenerate = div_st[NDIV].degen;
		for (int k = 0; k < tfn_pkg::AXES; k++) begin
			qc = (div_st[NDIV].quo[k] > tfn_pkg::QUO_W'(tfn_pkg::ONE_Q14)) ?
				tfn_pkg::QUO_W'(tfn_pkg::ONE_Q14) : div_st[NDIV].quo[k];
			if (!div_st[NDIV].degen) begin
				case (k)
					0: result.normal_x = div_st[NDIV].neg[k] ?
						-tfn_pkg::COORD_W'(qc) : tfn_pkg::COORD_W'(qc);
					1: result.normal_y = div_st[NDIV].neg[k] ?
						-tfn_pkg::COORD_W'(qc) : tfn_pkg::COORD_W'(qc);
					default: result.normal_z = div_st[NDIV].neg[k] ?
						-tfn_pkg::COORD_W'(qc) : tfn_pkg::COORD_W'(qc);
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_valid_q <= 1'b0;
		end else if (en) begin
			norm_valid_q <= div_valid[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_data_q <= result;
		end
	end

	assign norm_valid = norm_valid_q;
	assign norm_data  = norm_data_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

// Scoreboard for face normals: computes the expected unit normal of each
// accepted triangle and checks results against them in order.
class normal_scoreboard;
	tfn_pkg::norm_t pending_normals[$];
	int unsigned    mismatches;
	int unsigned    checked;
	int unsigned    degenerate_seen;

	// Integer square root, floor, by the bit-pair method.
	static function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	static function tfn_pkg::norm_t face_normal(tfn_pkg::vert_t t);
		longint          e0[3];
		longint          e1[3];
		longint          cr[3];
		longint unsigned mag[3];
		bit              neg[3];
		longint unsigned peak;
		longint unsigned sumsq;
		longint unsigned root;
		longint unsigned q;
		tfn_pkg::norm_t  res;
		e0[0] = longint'(t.vertex_b_x) - longint'(t.vertex_a_x);
		e0[1] = longint'(t.vertex_b_y) - longint'(t.vertex_a_y);
		e0[2] = longint'(t.vertex_b_z) - longint'(t.vertex_a_z);
		e1[0] = longint'(t.vertex_c_x) - longint'(t.vertex_b_x);
		e1[1] = longint'(t.vertex_c_y) - longint'(t.vertex_b_y);
		e1[2] = longint'(t.vertex_c_z) - longint'(t.vertex_b_z);
		cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
		cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
		cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
		peak = 0;
		for (int j = 0; j < 3; j++) begin
			neg[j] = cr[j] < 0;
			mag[j] = neg[j] ? longint'(-cr[j]) : longint'(cr[j]);
			if (mag[j] > peak)
				peak = mag[j];
		end
		res = '0;
		if (peak == 0) begin
			res.degenerate = 1'b1;
			return res;
		end
		// Bring the largest magnitude into [2^29, 2^30), truncating on right shifts.
		while (peak >= (64'd1 << 30)) begin
			peak = peak >> 1;
			for (int j = 0; j < 3; j++)
				mag[j] = mag[j] >> 1;
		end
		while (peak < (64'd1 << 29)) begin
			peak = peak << 1;
			for (int j = 0; j < 3; j++)
				mag[j] = mag[j] << 1;
		end
		sumsq = 0;
		for (int j = 0; j < 3; j++)
			sumsq = sumsq + mag[j] * mag[j];
		root = int_sqrt(sumsq);
		for (int j = 0; j < 3; j++) begin
			q = ((mag[j] << 15) + root) / (root << 1);
			if (q > tfn_pkg::ONE_Q14)
				q = tfn_pkg::ONE_Q14;
			q = neg[j] ? (64'd0 - q) : q;
			if (j == 0) res.normal_x = q[15:0];
			else if (j == 1) res.normal_y = q[15:0];
			else res.normal_z = q[15:0];
		end
		return res;
	endfunction

	function void note_triangle(tfn_pkg::vert_t t);
		pending_normals = {pending_normals, face_normal(t)};
	endfunction

	function void report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
		mismatches++;
	endfunction

	function void check_normal(tfn_pkg::norm_t got);
		tfn_pkg::norm_t want;
		if (pending_normals.size() == 0) begin
			report("result with no triangle outstanding", 1, 0);
			return;
		end
		want = pending_normals.pop_front();
		if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
		if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
		if (got.normal_z !== want.normal_z) report("normal_z", got.normal_z, want.normal_z);
		if (got.degenerate !== want.degenerate)
			report("degenerate", got.degenerate, want.degenerate);
		if (want.degenerate)
			degenerate_seen++;
		checked++;
	endfunction
endclass

module testbench;

	localparam int unsigned LATENCY = 54;

	logic           clk;
	logic           arst_n;
	logic           vert_valid;
	logic           vert_ready;
	tfn_pkg::vert_t vert_data;
	logic           norm_valid;
	logic           norm_ready;
	tfn_pkg::norm_t norm_data;

	// Idle percentages for the sender and the receiver, changed per phase.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned sent_count;

	normal_scoreboard normals;

	triangle_face_normal_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.vert_valid (vert_valid),
		.vert_ready (vert_ready),
		.vert_data  (vert_data),
		.norm_valid (norm_valid),
		.norm_ready (norm_ready),
		.norm_data  (norm_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// The receiver side: ready is redrawn each cycle, and each accepted
	// transaction is checked against the oldest expected normal.
	always @(posedge clk) begin
		if (arst_n && norm_valid && norm_ready)
			normals.check_normal(norm_data);
		norm_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offers one triangle after a random gap, holding it until it is accepted.
	// Valid stays high after acceptance so the next triangle can follow at once.
	task automatic send_triangle(input tfn_pkg::vert_t t);
		if ($urandom_range(99) < send_idle_pct) begin
			vert_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		vert_valid <= 1'b1;
		vert_data  <= t;
		@(posedge clk);
		while (!vert_ready)
			@(posedge clk);
		normals.note_triangle(t);
		sent_count++;
	endtask

	task automatic send_coords(input int ax, ay, az, bx, by, bz, cx, cy, cz);
		tfn_pkg::vert_t t;
		t.vertex_a_x = 16'(ax); t.vertex_a_y = 16'(ay); t.vertex_a_z = 16'(az);
		t.vertex_b_x = 16'(bx); t.vertex_b_y = 16'(by); t.vertex_b_z = 16'(bz);
		t.vertex_c_x = 16'(cx); t.vertex_c_y = 16'(cy); t.vertex_c_z = 16'(cz);
		send_triangle(t);
	endtask

	// Random coordinate: full range, a small box, or a pick among the extremes, zero and full range.
	function automatic logic [15:0] pick_coord(input int unsigned style);
		case (style)
			0: return 16'($urandom());
			1: return 16'($urandom_range(512) - 256);
			default: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'($urandom());
				endcase
			end
		endcase
	endfunction

	task automatic send_random_triangle();
		tfn_pkg::vert_t t;
		int unsigned    style;
		int unsigned    kind;
		style = $urandom_range(2);
		t = {pick_coord(style), pick_coord(style), pick_coord(style),
			pick_coord(style), pick_coord(style), pick_coord(style),
			pick_coord(style), pick_coord(style), pick_coord(style)};
		kind = $urandom_range(9);
		// Some triangles are made degenerate by repeating vertices or, barring wrap-around, by aligning them.
		if (kind == 0) begin
			t.vertex_b_x = t.vertex_a_x; t.vertex_b_y = t.vertex_a_y;
			t.vertex_b_z = t.vertex_a_z;
		end else if (kind == 1) begin
			t.vertex_c_x = t.vertex_b_x + (t.vertex_b_x - t.vertex_a_x);
			t.vertex_c_y = t.vertex_b_y + (t.vertex_b_y - t.vertex_a_y);
			t.vertex_c_z = t.vertex_b_z + (t.vertex_b_z - t.vertex_a_z);
		end
		send_triangle(t);
	endtask

	// Stops offering and waits until every expected normal has come back.
	task automatic wait_drained();
		vert_valid <= 1'b0;
		while (normals.pending_normals.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		normals        = new();
		arst_n         = 1'b0;
		vert_valid     = 1'b0;
		vert_data      = '0;
		norm_ready     = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		sent_count     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed triangles: unit axes, each sign, extremes, and degenerate cases.
		send_coords(0, 0, 0, 256, 0, 0, 256, 256, 0);
		send_coords(0, 0, 0, 0, 256, 0, 0, 256, 256);
		send_coords(0, 0, 0, 0, 0, 256, 256, 0, 256);
		send_coords(0, 0, 0, 0, 256, 0, 256, 256, 0);
		send_coords(0, 0, 0, 1, 0, 0, 1, 1, 0);
		send_coords(-32768, -32768, -32768, 32767, -32768, -32768, 32767, 32767, -32768);
		send_coords(32767, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 32767);
		send_coords(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768);
		send_coords(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767);
		send_coords(-1, -1, -1, 0, 0, 0, 1, 2, 3);
		send_coords(100, 200, 300, 100, 200, 300, 100, 200, 300);
		send_coords(5, 5, 5, 5, 5, 5, 900, -40, 7);
		send_coords(0, 0, 0, 256, 256, 256, 512, 512, 512);
		send_coords(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767);
		send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_coords(0, 0, 0, 1, 0, 0, 0, 32767, 1);
		send_coords(0, 0, 0, 1, 1, 0, 2, 3, 1);
		send_coords(-21846, 21845, 10922, 21845, -10923, -21846, 10922, 21845, -32768);

		// Pause until the pipeline has emptied before the random phases.
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			repeat (420) send_random_triangle();
			if (phase == 1)
				wait_drained();
		end

		recv_stall_pct = 0;
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		$display("Checked %0d face normals from %0d triangles, %0d of them degenerate,",
			normals.checked, sent_count, normals.degenerate_seen);
		$display("over phases with no idling, sender gaps, receiver stalls and both.");
		if (normals.mismatches == 0 && normals.pending_normals.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Slowest case: about 1700 triangles, some facing long sender gaps and some long receiver stalls.
	initial begin
		#20ms;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/tfn_pkg.sv
hdl/tfn_front.sv
hdl/tfn_sqrt_cell.sv
hdl/tfn_div_cell.sv
hdl/triangle_face_normal_core.sv
test/testbench.sv
